// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file agu_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define AST_ALWAYS(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Same check, but also enforced while reset is asserted.
`define AST_NORST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: hw/rtl/agu_pkg.sv
// Package for the AdaGrad update block: FSM states, control structs,
// register indexes and iteration counts. No dependencies.
`timescale 1ns / 1ps

package agu_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 64;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_DECAY = 2'd1;
  localparam logic [1:0] CFG_EPS   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CACHE,
    ST_SQRT,
    ST_RATE,
    ST_RDIV,
    ST_STEP,
    ST_SDIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic cache;
    logic sqrt_step;
    logic rate_init;
    logic div_step;
    logic step_init;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/agu_ctrl.sv
// Sequencer for the AdaGrad update: walks the datapath through cache update,
// square root and the two divisions. Depends on agu_pkg.
`timescale 1ns / 1ps

module agu_ctrl import agu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CACHE;
      ST_CACHE: state_d = ST_SQRT;
      ST_SQRT:  if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = ST_RATE;
      ST_RATE:  state_d = ST_RDIV;
      ST_RDIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_STEP;
      ST_STEP:  state_d = ST_SDIV;
      ST_SDIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_DONE;
      ST_DONE:  if (stat_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cnt_d      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CACHE: cmd_o.cache = 1'b1;
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
      end
      ST_RATE: cmd_o.rate_init = 1'b1;
      ST_RDIV, ST_SDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      ST_STEP: cmd_o.step_init = 1'b1;
      ST_DONE: cmd_o.finish = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: hw/rtl/agu_dpath.sv
// Datapath for the AdaGrad update: config and pass registers, cache update,
// bit-serial square root, shared restoring divider, output register.
// Depends on agu_pkg.
`timescale 1ns / 1ps

module agu_dpath import agu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic signed [31:0] param_value_i,
  input  logic [31:0]        cache_value_i,
  input  logic signed [31:0] gradient_i,
  input  logic               last_in_pass_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] new_param_o,
  output logic [31:0]        new_cache_o,
  output logic               saturated_o
);

  localparam logic [63:0] ONE      = 64'd1 << FRAC_BITS;
  localparam logic [63:0] STEP_MAX = 64'd1 << 33;

  logic [31:0] base_q, decay_q, pass_q;
  logic [15:0] eps_q;

  logic signed [31:0] param_q;
  logic               g_neg_q, last_q, sat_q;
  logic [31:0]        gmag_q, cache_q;

  logic [63:0] sx_q;
  logic [32:0] srem_q;
  logic [31:0] root_q;
  logic [32:0] den_q;

  logic [63:0] num_q, dvs_q, quo_q;
  logic [63:0] rem_q;

  logic               ov_q;
  logic signed [31:0] op_q;
  logic [31:0]        oc_q;
  logic               os_q;

  logic [31:0] gmag_in;
  logic [63:0] sq_prod, sq_shr;
  logic [64:0] csum;
  logic        csat;
  logic [31:0] cache_new;
  logic [34:0] srem_sh, trial;
  logic        sge;
  logic [64:0] rem_sh;
  logic        dge;
  logic [32:0] den_raw;
  logic [33:0] step;
  logic signed [35:0] p_ext, s_ext, np;
  logic signed [31:0] np_sat;
  logic        np_ovf;

  assign gmag_in   = gradient_i[31] ? 32'(-gradient_i) : gradient_i;
  assign sq_prod   = {32'b0, gmag_q} * {32'b0, gmag_q};
  assign sq_shr    = sq_prod >> FRAC_BITS;
  assign csum      = {1'b0, 32'b0, cache_q} + {1'b0, sq_shr};
  assign csat      = |csum[64:32];
  assign cache_new = csat ? 32'hFFFF_FFFF : csum[31:0];

  assign srem_sh = {srem_q, sx_q[63:62]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign sge     = srem_sh >= trial;

  assign rem_sh = {rem_q, num_q[63]};
  assign dge    = rem_sh >= {1'b0, dvs_q};

  assign den_raw = {1'b0, root_q} + {17'b0, eps_q};

  assign step   = (quo_q > STEP_MAX) ? STEP_MAX[33:0] : quo_q[33:0];
  assign p_ext  = {{4{param_q[31]}}, param_q};
  assign s_ext  = {2'b00, step};
  assign np     = g_neg_q ? p_ext + s_ext : p_ext - s_ext;
  assign np_ovf = (np > 36'sd2147483647) || (np < -36'sd2147483648);
  assign np_sat = (np > 36'sd2147483647) ? 32'sh7FFF_FFFF :
                  (np < -36'sd2147483648) ? 32'sh8000_0000 : np[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 32'd65536;
      decay_q <= '0;
      eps_q   <= 16'd1;
      pass_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BASE:  base_q  <= cfg_data_i;
          CFG_DECAY: decay_q <= cfg_data_i;
          CFG_EPS:   eps_q   <= cfg_data_i[15:0];
          default:   ;
        endcase
      end
      if (cmd_i.finish && last_q && pass_q != 32'hFFFF_FFFF) pass_q <= pass_q + 1'b1;
      if (cmd_i.finish) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      param_q <= param_value_i;
      cache_q <= cache_value_i;
      g_neg_q <= gradient_i[31];
      gmag_q  <= gmag_in;
      last_q  <= last_in_pass_i;
    end
    if (cmd_i.cache) begin
      cache_q <= cache_new;
      sat_q   <= csat;
      sx_q    <= {32'b0, cache_new} << FRAC_BITS;
      srem_q  <= '0;
      root_q  <= '0;
    end
    if (cmd_i.sqrt_step) begin
      sx_q   <= sx_q << 2;
      srem_q <= sge ? 33'(srem_sh - trial) : srem_sh[32:0];
      root_q <= {root_q[30:0], sge};
    end
    if (cmd_i.rate_init) begin
      den_q <= (den_raw == '0) ? 33'd1 : den_raw;
      num_q <= {32'b0, base_q} << FRAC_BITS;
      dvs_q <= ({32'b0, decay_q} * {32'b0, pass_q}) + ONE;
      rem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.step_init) begin
      num_q <= {32'b0, quo_q[31:0]} * {32'b0, gmag_q};
      dvs_q <= {31'b0, den_q};
      rem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      rem_q <= dge ? 64'(rem_sh - {1'b0, dvs_q}) : rem_sh[63:0];
      quo_q <= {quo_q[62:0], dge};
    end
    if (cmd_i.finish) begin
      op_q <= np_sat;
      oc_q <= cache_q;
      os_q <= sat_q | np_ovf;
    end
  end

  assign stat_o.out_free = !ov_q || out_ready_i;
  assign out_valid_o     = ov_q;
  assign new_param_o     = op_q;
  assign new_cache_o     = oc_q;
  assign saturated_o     = os_q;

endmodule

// File: hw/rtl/adagrad_param_update.sv
// AdaGrad parameter update, one item at a time: accept, cache update,
// 32 square-root steps, rate-division setup and 64 divide steps, step-division
// setup and 64 divide steps (shared restoring divider), finish; the result is
// registered at the finish, and the finish waits while the previous one is held.
// Reset (async, active low) restores base_rate 1.0, decay 0, epsilon 1, pass 0.
// Depends on agu_pkg, agu_ctrl, agu_dpath.
`timescale 1ns / 1ps

module adagrad_param_update import agu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // param_value, cache_value, gradient
  input  logic        s_axis_tlast,  // last_in_pass
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // new_param, new_cache
  output logic        m_axis_tuser,  // saturated
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t               cmd;
  stat_t              stat;
  logic signed [31:0] new_param;
  logic [31:0]        new_cache;

  agu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  agu_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .param_value_i  (s_axis_tdata[31:0]),
    .cache_value_i  (s_axis_tdata[63:32]),
    .gradient_i     (s_axis_tdata[95:64]),
    .last_in_pass_i (s_axis_tlast),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .new_param_o    (new_param),
    .new_cache_o    (new_cache),
    .saturated_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {new_cache, new_param};

endmodule

// File: hw/rtl/agu_checker.sv
// Port-level checks for adagrad_param_update, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module agu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `AST_ALWAYS(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `AST_ALWAYS(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `AST_ALWAYS(a_result_from_busy, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

endmodule

bind adagrad_param_update agu_checker u_agu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
